[rtl/core/xxhash64_stream_hasher_top_defines.svh]
// assertion macros for the xxhash64 stream hasher
`ifndef XXHASH64_STREAM_HASHER_TOP_DEFINES_SVH
`define XXHASH64_STREAM_HASHER_TOP_DEFINES_SVH

// implication checked on every edge outside reset
`define XXH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define XXH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/xxh_pkg.sv]
// shared constants, types and helpers for the xxhash64 stream hasher
`timescale 1ns / 1ps
package xxh_pkg;

   localparam int unsigned LengthWidthDefault = 64;

   localparam logic [63:0] Prime1 = 64'd11400714785074694791;
   localparam logic [63:0] Prime2 = 64'd14029467366897019727;
   localparam logic [63:0] Prime3 = 64'd1609587929392839161;
   localparam logic [63:0] Prime4 = 64'd9650029242287828579;
   localparam logic [63:0] Prime5 = 64'd2870177450012600261;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,      // load lanes from seed
      OP_WORD,       // accept word: length, tail or round setup
      OP_ROUND_MUL,  // acc + x*P2 step
      OP_ROUND_FIN,  // rotl 31 and *P1 into lane
      OP_INIT_H,     // merge start, or seed+P5 plus length
      OP_MERGE_A,    // round(0,lane) part 1
      OP_MERGE_B,    // rotl 31 and *P1 into r, then h ^= r; h*P1
      OP_MERGE_C,    // +P4, plus length after the last lane
      OP_TAIL8_A,
      OP_TAIL8_B,
      OP_TAIL4,
      OP_TAIL1,
      OP_AVAL_A,
      OP_AVAL_B,
      OP_AVAL_C
   } xxh_op_type;

   typedef struct packed {
      xxh_op_type  op;
      logic [1:0]  sel;     // lane or tail index
      logic        last_b;  // second sub-step
      logic        hold;    // first multiply cycle, operands only
   } xxh_cmd_type;

   typedef struct packed {
      logic       long_msg;    // length at least 32
      logic [1:0] tail_count;
      logic       round_due;   // a full stripe is ready
      logic [3:0] rem_bytes;   // bytes of the final partial word left
   } xxh_status_type;

   function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
      rotl64 = (x << r) | (x >> (64 - r));
   endfunction

endpackage

[rtl/core/xxh_stream_if.sv]
// valid/ready channel interface carrying the payload struct
`timescale 1ns / 1ps
interface xxh_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/xxh_datapath.sv]
// lane accumulators, tail store and a shared 64-bit multiplier
`timescale 1ns / 1ps
module xxh_datapath
   import xxh_pkg::*;
#(
   parameter int unsigned LENGTH_WIDTH = LengthWidthDefault
) (
   input  logic           clock,
   input  logic           reset,
   input  xxh_cmd_type    cmd,
   input  logic [63:0]    seed_value,
   input  logic [63:0]    data_word,
   input  logic [3:0]     valid_bytes,
   input  logic           end_flag,
   output xxh_status_type status,
   output logic [63:0]    hash_value
);

   logic [63:0]             lane_ff [4];
   logic [63:0]             lane_in [4];
   logic [63:0]             tail_ff [3];
   logic [63:0]             word_ff, word_in;
   logic [1:0]              tcnt_ff, tcnt_in;
   logic [LENGTH_WIDTH-1:0] len_ff, len_in;
   logic [63:0]             seed_ff, seed_in;
   logic [63:0]             h_ff, h_in;
   logic [63:0]             t_ff, t_in;
   logic [63:0]             part_ff, part_in;
   logic [3:0]              rem_ff, rem_in;
   logic                    due_ff, due_in;
   logic [63:0]             mul_a, mul_b, prod;
   logic [63:0]             plo_ff;
   logic [31:0]             pmid_ff, pcross_ff;
   logic [3:0]              nb;
   logic                    tail_we;
   logic [1:0]              tail_wa;
   logic [LENGTH_WIDTH-1:0] base_len;
   logic [1:0]              base_cnt;

   // low 64 bits of the product from registered 32x32 partial products
   assign prod = plo_ff + {pmid_ff + pcross_ff, 32'd0};
   assign nb = (!end_flag || valid_bytes > 4'd8) ? 4'd8 : valid_bytes;

   always_comb begin
      mul_a = '0;
      mul_b = Prime1;
      unique case (cmd.op) inside
         OP_ROUND_MUL: begin
            mul_a = (cmd.sel == 2'd3) ? word_ff : tail_ff[cmd.sel];
            mul_b = Prime2;
         end
         OP_ROUND_FIN: mul_a = rotl64(t_ff, 31);
         OP_MERGE_A: begin
            mul_a = lane_ff[cmd.sel];
            mul_b = Prime2;
         end
         OP_TAIL8_A: begin
            mul_a = tail_ff[cmd.sel];
            mul_b = Prime2;
         end
         OP_MERGE_B: begin
            mul_a = cmd.last_b ? (h_ff ^ t_ff) : rotl64(t_ff, 31);
            mul_b = Prime1;
         end
         OP_TAIL8_B: begin
            mul_a = cmd.last_b ? rotl64(h_ff ^ t_ff, 27) : rotl64(t_ff, 31);
            mul_b = Prime1;
         end
         OP_TAIL4: begin
            mul_a = cmd.last_b ? rotl64(h_ff, 23) : {32'd0, part_ff[31:0]};
            mul_b = cmd.last_b ? Prime2 : Prime1;
         end
         OP_TAIL1: begin
            mul_a = cmd.last_b ? rotl64(h_ff, 11) : {56'd0, part_ff[7:0]};
            mul_b = cmd.last_b ? Prime1 : Prime5;
         end
         OP_AVAL_A: begin
            mul_a = h_ff ^ (h_ff >> 33);
            mul_b = Prime2;
         end
         OP_AVAL_B: begin
            mul_a = h_ff ^ (h_ff >> 29);
            mul_b = Prime3;
         end
         default: ;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 4; i++) lane_in[i] = lane_ff[i];
      word_in  = word_ff;
      tcnt_in  = tcnt_ff;
      len_in   = len_ff;
      seed_in  = seed_ff;
      h_in     = h_ff;
      t_in     = t_ff;
      part_in  = part_ff;
      rem_in   = rem_ff;
      due_in   = due_ff;
      tail_we  = 1'b0;
      base_len = len_ff;
      base_cnt = tcnt_ff;
      tail_wa  = tcnt_ff;
      if (!cmd.hold) begin
         unique case (cmd.op) inside
            OP_START, OP_WORD: begin
               if (cmd.op == OP_START) begin
                  seed_in    = seed_value;
                  lane_in[0] = seed_value + Prime1 + Prime2;
                  lane_in[1] = seed_value + Prime2;
                  lane_in[2] = seed_value;
                  lane_in[3] = seed_value - Prime1;
                  base_len   = '0;
                  base_cnt   = '0;
               end
               len_in  = base_len + LENGTH_WIDTH'(nb);
               word_in = data_word;
               part_in = data_word;
               due_in  = 1'b0;
               rem_in  = 4'd0;
               tcnt_in = base_cnt;
               tail_wa = base_cnt;
               if (nb == 4'd8) begin
                  if (base_cnt == 2'd3) begin
                     due_in  = 1'b1;
                     tcnt_in = '0;
                  end else begin
                     tail_we = 1'b1;
                     tcnt_in = base_cnt + 2'd1;
                  end
               end else begin
                  rem_in = nb;
               end
            end
            OP_ROUND_MUL: t_in = lane_ff[cmd.sel] + prod;
            OP_ROUND_FIN: begin
               lane_in[cmd.sel] = prod;
               if (cmd.sel == 2'd3) due_in = 1'b0;
            end
            OP_INIT_H: begin
               if (status.long_msg)
                  h_in = rotl64(lane_ff[0], 1) + rotl64(lane_ff[1], 7)
                       + rotl64(lane_ff[2], 12) + rotl64(lane_ff[3], 18);
               else
                  h_in = seed_ff + Prime5 + 64'(len_ff);
            end
            OP_MERGE_A, OP_TAIL8_A: t_in = prod;
            OP_MERGE_B: begin
               if (cmd.last_b) h_in = prod;
               else t_in = prod;
            end
            OP_MERGE_C: h_in = h_ff + Prime4 + ((cmd.sel == 2'd3) ? 64'(len_ff) : 64'd0);
            OP_TAIL8_B: begin
               if (cmd.last_b) h_in = prod + Prime4;
               else t_in = prod;
            end
            OP_TAIL4: begin
               if (cmd.last_b) begin
                  h_in    = prod + Prime3;
                  part_in = part_ff >> 32;
                  rem_in  = rem_ff - 4'd4;
               end else begin
                  h_in = h_ff ^ prod;
               end
            end
            OP_TAIL1: begin
               if (cmd.last_b) begin
                  h_in    = prod;
                  part_in = part_ff >> 8;
                  rem_in  = rem_ff - 4'd1;
               end else begin
                  h_in = h_ff ^ prod;
               end
            end
            OP_AVAL_A, OP_AVAL_B: h_in = prod;
            OP_AVAL_C: h_in = h_ff ^ (h_ff >> 32);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) lane_ff[i] <= '0;
         tcnt_ff <= '0;
         len_ff  <= '0;
         seed_ff <= '0;
         due_ff  <= 1'b0;
         rem_ff  <= '0;
      end else begin
         for (int i = 0; i < 4; i++) lane_ff[i] <= lane_in[i];
         tcnt_ff <= tcnt_in;
         len_ff  <= len_in;
         seed_ff <= seed_in;
         due_ff  <= due_in;
         rem_ff  <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      h_ff      <= h_in;
      t_ff      <= t_in;
      part_ff   <= part_in;
      plo_ff    <= 64'(mul_a[31:0]) * 64'(mul_b[31:0]);
      pmid_ff   <= mul_a[63:32] * mul_b[31:0];
      pcross_ff <= mul_a[31:0] * mul_b[63:32];
      if (tail_we) tail_ff[tail_wa] <= data_word;
   end

   assign status.long_msg   = (len_ff >= LENGTH_WIDTH'(32));
   assign status.tail_count = tcnt_ff;
   assign status.round_due  = due_ff;
   assign status.rem_bytes  = rem_ff;
   assign hash_value        = h_ff;

endmodule

[rtl/core/xxh_control.sv]
// sequencer for lane rounds, finalization and result handshake
`timescale 1ns / 1ps
`include "xxhash64_stream_hasher_top_defines.svh"
module xxh_control
   import xxh_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic           start_flag,
   input  logic           end_flag,
   input  xxh_status_type status,
   output xxh_cmd_type    cmd,
   output logic           out_valid,
   input  logic           out_ready
);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_RMUL  = 10'b0000000010,
      ST_RFIN  = 10'b0000000100,
      ST_INIT  = 10'b0000001000,
      ST_MERGE = 10'b0000010000,
      ST_TAIL8 = 10'b0000100000,
      ST_TAIL4 = 10'b0001000000,
      ST_TAIL1 = 10'b0010000000,
      ST_AVAL  = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   state_type  state_ff, state_in;
   logic       open_ff, open_in;
   logic       fin_ff, fin_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] sub_ff, sub_in;
   logic       ph_ff, ph_in;
   logic       mul_op;
   logic       take;

   assign in_ready  = (state_ff == ST_IDLE);
   assign take      = in_valid && in_ready;
   assign out_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      open_in  = open_ff;
      fin_in   = fin_ff;
      idx_in   = idx_ff;
      sub_in   = sub_ff;
      cmd      = '{op: OP_NONE, sel: idx_ff, last_b: sub_ff[0], hold: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (take && (start_flag || open_ff)) begin
               cmd.op   = start_flag ? OP_START : OP_WORD;
               open_in  = !end_flag;
               fin_in   = end_flag;
               idx_in   = '0;
               sub_in   = '0;
               state_in = ST_RMUL;
            end
         end
         ST_RMUL: begin
            if (!status.round_due) begin
               state_in = fin_ff ? ST_INIT : ST_IDLE;
            end else begin
               cmd.op   = OP_ROUND_MUL;
               state_in = ST_RFIN;
            end
         end
         ST_RFIN: begin
            cmd.op = OP_ROUND_FIN;
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd3) state_in = fin_ff ? ST_INIT : ST_IDLE;
            else state_in = ST_RMUL;
         end
         ST_INIT: begin
            cmd.op   = OP_INIT_H;
            idx_in   = '0;
            sub_in   = '0;
            state_in = status.long_msg ? ST_MERGE : ST_TAIL8;
         end
         ST_MERGE: begin
            cmd.op = (sub_ff == 2'd0) ? OP_MERGE_A
                   : (sub_ff == 2'd3) ? OP_MERGE_C : OP_MERGE_B;
            cmd.last_b = (sub_ff == 2'd2);
            sub_in = sub_ff + 2'd1;
            if (sub_ff == 2'd3) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  idx_in   = '0;
                  state_in = ST_TAIL8;
               end
            end
         end
         ST_TAIL8: begin
            if (idx_ff == status.tail_count) begin
               sub_in   = '0;
               state_in = ST_TAIL4;
            end else begin
               cmd.op     = (sub_ff == 2'd0) ? OP_TAIL8_A : OP_TAIL8_B;
               cmd.last_b = (sub_ff == 2'd2);
               sub_in     = sub_ff + 2'd1;
               if (sub_ff == 2'd2) begin
                  sub_in = '0;
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         ST_TAIL4: begin
            if (status.rem_bytes < 4'd4) begin
               sub_in   = '0;
               state_in = ST_TAIL1;
            end else begin
               cmd.op     = OP_TAIL4;
               cmd.last_b = sub_ff[0];
               sub_in     = {1'b0, ~sub_ff[0]};
            end
         end
         ST_TAIL1: begin
            if (status.rem_bytes == 4'd0) begin
               sub_in   = '0;
               state_in = ST_AVAL;
            end else begin
               cmd.op     = OP_TAIL1;
               cmd.last_b = sub_ff[0];
               sub_in     = {1'b0, ~sub_ff[0]};
            end
         end
         ST_AVAL: begin
            cmd.op = (sub_ff == 2'd0) ? OP_AVAL_A
                   : (sub_ff == 2'd1) ? OP_AVAL_B : OP_AVAL_C;
            sub_in = sub_ff + 2'd1;
            if (sub_ff == 2'd2) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // a multiply first registers its partial products under hold, then writes
      mul_op = cmd.op inside {OP_ROUND_MUL, OP_ROUND_FIN, OP_MERGE_A, OP_MERGE_B,
                              OP_TAIL8_A, OP_TAIL8_B, OP_TAIL4, OP_TAIL1,
                              OP_AVAL_A, OP_AVAL_B};
      ph_in = 1'b0;
      if (mul_op && !ph_ff) begin
         cmd.hold = 1'b1;
         state_in = state_ff;
         open_in  = open_ff;
         fin_in   = fin_ff;
         idx_in   = idx_ff;
         sub_in   = sub_ff;
         ph_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         open_ff  <= 1'b0;
         fin_ff   <= 1'b0;
         idx_ff   <= '0;
         sub_ff   <= '0;
         ph_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         open_ff  <= open_in;
         fin_ff   <= fin_in;
         idx_ff   <= idx_in;
         sub_ff   <= sub_in;
         ph_ff    <= ph_in;
      end
   end

   `XXH_ASSERT_IMP(a_out_only_done, clock, reset, out_valid, !in_ready, "result and input both open")
   `XXH_ASSERT_NEXT(a_out_holds, clock, reset, out_valid && !out_ready, out_valid, "result dropped")
   `XXH_ASSERT_IMP(a_round_in_msg, clock, reset, state_ff == ST_RFIN, status.round_due, "round without stripe")
   `XXH_ASSERT_NEXT(a_hold_once, clock, reset, cmd.hold, !cmd.hold, "multiply held twice")

endmodule

[rtl/core/xxhash64_stream_hasher_top.sv]
// xxhash64 stream hasher top level
//
// req channel: one 64-bit little-endian message word per beat with start_flag,
// seed_value (taken on start), valid_bytes and end_flag. rsp channel: one
// 64-bit hash per message, issued after the final word.
// Every multiply uses one shared unit of 32x32 partial products, registered
// before the result is written. A word that completes a 32-byte stripe
// then runs four lane rounds of two multiplies each.
// The final word then seeds the hash, merges the lanes when the length is
// at least 32, folds in each held tail word, a 4-byte step and each
// trailing byte, with a check that ends each of the tail, 4-byte and byte
// steps, runs the avalanche and presents the hash.
// Words with start_flag low outside a message are dropped without result.
// One item is worked at a time; req_ready is high only in the idle state.
// Reset returns to idle, closes any open message and clears lanes and length.
// When the receiver stalls, the hash is held on rsp until taken and no new
// word is accepted in the meantime.
`timescale 1ns / 1ps
module xxhash64_stream_hasher_top
   import xxh_pkg::*;
#(
   parameter int unsigned LENGTH_WIDTH = LengthWidthDefault
) (
   input  logic clock,
   input  logic reset,
   xxh_stream_if.sink   req,
   xxh_stream_if.source rsp
);

   xxh_cmd_type    cmd;
   xxh_status_type status;
   logic [63:0]    hash;

   xxh_control u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req.valid),
      .in_ready   (req.ready),
      .start_flag (req.payload.start_flag),
      .end_flag   (req.payload.end_flag),
      .status     (status),
      .cmd        (cmd),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready)
   );

   xxh_datapath #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .seed_value  (req.payload.seed_value),
      .data_word   (req.payload.data_word),
      .valid_bytes (req.payload.valid_bytes),
      .end_flag    (req.payload.end_flag),
      .status      (status),
      .hash_value  (hash)
   );

   assign rsp.payload.hash_value = hash;

endmodule

[dv/testbench.sv]
// self-checking testbench for the xxhash64 stream hasher top level
`timescale 1ns / 1ps
module testbench
   import xxh_pkg::*;
();

   typedef struct packed {
      logic        start_flag;
      logic [63:0] seed_value;
      logic [63:0] data_word;
      logic [3:0]  valid_bytes;
      logic        end_flag;
   } req_beat_type;

   typedef struct packed {
      logic [63:0] hash_value;
   } hash_beat_type;

   localparam int QuietLimit = 4000;
   localparam int DrainCycles = 80;
   localparam int ItemsPerPhase = 510;

   class hash_scoreboard;
      logic [63:0] lane[4];
      logic [63:0] tail[3];
      int unsigned held;
      logic [63:0] length;
      logic [63:0] seed;
      bit          open;
      logic [63:0] pending_hash[$];
      int          mismatches;

      function new();
         foreach (lane[i]) lane[i] = '0;
         foreach (tail[i]) tail[i] = '0;
         held = 0;
         length = '0;
         seed = '0;
         open = 0;
         mismatches = 0;
      endfunction

      function logic [63:0] rotate_left(logic [63:0] x, int unsigned r);
         return (x << r) | (x >> (64 - r));
      endfunction

      function logic [63:0] lane_mix(logic [63:0] acc, logic [63:0] x);
         return rotate_left(acc + x * Prime2, 31) * Prime1;
      endfunction

      function void absorb(logic [63:0] w);
         if (held == 3) begin
            lane[0] = lane_mix(lane[0], tail[0]);
            lane[1] = lane_mix(lane[1], tail[1]);
            lane[2] = lane_mix(lane[2], tail[2]);
            lane[3] = lane_mix(lane[3], w);
            held = 0;
         end else begin
            tail[held] = w;
            held++;
         end
      endfunction

      function logic [63:0] finalize(logic [63:0] part, int unsigned nbytes);
         logic [63:0] h;
         if (length >= 32) begin
            h = rotate_left(lane[0], 1) + rotate_left(lane[1], 7) +
                rotate_left(lane[2], 12) + rotate_left(lane[3], 18);
            for (int i = 0; i < 4; i++) h = (h ^ lane_mix(64'd0, lane[i])) * Prime1 + Prime4;
         end else begin
            h = seed + Prime5;
         end
         h += length;
         for (int i = 0; i < held; i++) begin
            h ^= lane_mix(64'd0, tail[i]);
            h = rotate_left(h, 27) * Prime1 + Prime4;
         end
         if (nbytes >= 4) begin
            h ^= {32'd0, part[31:0]} * Prime1;
            h = rotate_left(h, 23) * Prime2 + Prime3;
            part >>= 32;
            nbytes -= 4;
         end
         while (nbytes > 0) begin
            h ^= {56'd0, part[7:0]} * Prime5;
            h = rotate_left(h, 11) * Prime1;
            part >>= 8;
            nbytes--;
         end
         h ^= h >> 33;
         h *= Prime2;
         h ^= h >> 29;
         h *= Prime3;
         h ^= h >> 32;
         return h;
      endfunction

      function void note_word(req_beat_type b);
         int unsigned n;
         if (b.start_flag) begin
            seed = b.seed_value;
            lane[0] = seed + Prime1 + Prime2;
            lane[1] = seed + Prime2;
            lane[2] = seed;
            lane[3] = seed - Prime1;
            held = 0;
            length = '0;
            open = 1;
         end
         if (!open) return;
         n = 32'(b.valid_bytes);
         if (!b.end_flag || n > 8) n = 8;
         length += 64'(n);
         if (!b.end_flag) begin
            absorb(b.data_word);
            return;
         end
         if (n == 8) begin
            absorb(b.data_word);
            pending_hash = {pending_hash, finalize('0, 0)};
         end else begin
            pending_hash = {pending_hash, finalize(b.data_word, n)};
         end
         open = 0;
      endfunction

      function void check_hash(logic [63:0] got);
         logic [63:0] want;
         if (pending_hash.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected hash beat: %h", got);
            return;
         end
         want = pending_hash.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("hash mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   tx_pct;
   int   rx_pct;
   int   quiet;
   int   items;
   hash_scoreboard sb;

   xxh_stream_if #(.payload_type(req_beat_type))  req_if ();
   xxh_stream_if #(.payload_type(hash_beat_type)) rsp_if ();

   xxhash64_stream_hasher_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet <= 0;
         else quiet <= quiet + 1;
         if (req_if.valid && req_if.ready) sb.note_word(req_if.payload);
         if (rsp_if.valid && rsp_if.ready) sb.check_hash(rsp_if.payload.hash_value);
         if (quiet >= QuietLimit) begin
            $display("TEST FAILED");
            $finish;
         end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= rx_pct);
   end

   task automatic send_word(bit start, logic [63:0] seed, logic [63:0] word,
                            logic [3:0] nbytes, bit last);
      req_beat_type b;
      b.start_flag = start;
      b.seed_value = seed;
      b.data_word = word;
      b.valid_bytes = nbytes;
      b.end_flag = last;
      while ($urandom_range(0, 99) < tx_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_message(int words, bit finish_it);
      logic [63:0] seed;
      logic [3:0]  nb;
      seed = rand64();
      for (int i = 0; i < words; i++) begin
         if (i == words - 1 && finish_it) nb = 4'($urandom_range(0, 15));
         else nb = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
         send_word(i == 0, seed, rand64(), nb, finish_it && i == words - 1);
      end
   endtask

   task automatic run_phase(int target);
      int stop;
      int pick;
      stop = items + target;
      while (items < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) send_word(1'b0, rand64(), rand64(), 4'($urandom_range(0, 15)),
                                 1'($urandom));
         else if (pick < 12) send_message($urandom_range(1, 6), 1'b0);
         else if (pick < 25) send_message($urandom_range(9, 40), 1'b1);
         else send_message($urandom_range(1, 8), 1'b1);
      end
   endtask

   initial begin
      sb = new();
      quiet = 0;
      items = 0;
      tx_pct = 29;
      rx_pct = 47;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: single-word messages and field extremes
      send_word(1'b1, '0, '0, 4'd0, 1'b1);
      send_word(1'b1, '1, '1, 4'd8, 1'b1);
      send_word(1'b1, '1, 64'h0123456789abcdef, 4'd4, 1'b1);
      send_word(1'b1, 64'h5, 64'hfedcba9876543210, 4'd3, 1'b1);
      send_word(1'b1, 64'h7, '1, 4'd15, 1'b1);
      send_word(1'b1, 64'h9, '1, 4'd1, 1'b1);
      // word outside a message is dropped
      send_word(1'b0, '1, '1, 4'd8, 1'b1);
      // short word before the end counts as full
      send_word(1'b1, 64'h11, 64'haaaa5555aaaa5555, 4'd2, 1'b0);
      send_word(1'b0, '0, 64'h5555aaaa5555aaaa, 4'd7, 1'b1);
      // exactly 32 bytes, then a stripe plus tail
      for (int i = 0; i < 4; i++) send_word(i == 0, 64'h33, rand64(), 4'd8, i == 3);
      for (int i = 0; i < 7; i++) send_word(i == 0, '1, '1, 4'd8, i == 6);
      // restart inside an open message
      send_word(1'b1, 64'h44, rand64(), 4'd8, 1'b0);
      send_word(1'b1, 64'h45, rand64(), 4'd6, 1'b1);

      run_phase(ItemsPerPhase);
      tx_pct = 47; rx_pct = 29;
      run_phase(ItemsPerPhase);
      tx_pct = 0; rx_pct = 0;
      run_phase(ItemsPerPhase);
      req_if.valid <= 1'b0;

      while (sb.pending_hash.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/xxh_pkg.sv
rtl/core/xxh_stream_if.sv
rtl/core/xxh_datapath.sv
rtl/core/xxh_control.sv
rtl/core/xxhash64_stream_hasher_top.sv
dv/testbench.sv
